@@ src/pmfb_pkg.sv @@
// Package for the paged monochrome frame buffer engine.
// Frame geometry, field widths, command and status codes, queue entry type.
// No dependencies.
`default_nettype none

package pmfb_pkg;

  localparam int unsigned FRAME_COLUMNS = 128;
  localparam int unsigned FRAME_ROWS    = 64;
  localparam int unsigned PAGE_COUNT    = FRAME_ROWS / 8;
  localparam int unsigned STORE_BYTES   = FRAME_COLUMNS * PAGE_COUNT;

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned PG_W   = $clog2(PAGE_COUNT + 1);
  localparam int unsigned PCNT_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned COL_W  = $clog2(FRAME_COLUMNS + 1);
  localparam int unsigned CMP_W  = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned X_W      = 7;
  localparam int unsigned Y_W      = 6;
  localparam int unsigned BW_W     = 8;
  localparam int unsigned BH_W     = 7;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned RIDX_W   = 10;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 3'd0,
    CMD_SET_PIXEL  = 3'd1,
    CMD_START_BLIT = 3'd2,
    CMD_BLIT_BYTE  = 3'd3,
    CMD_READ_BYTE  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_SETBIT,
    OP_READ,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    op_kind_e            kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    status_e             status;
    logic                done;
  } op_t;

endpackage

`default_nettype wire

@@ src/pmfb_if.sv @@
// Request and result channel interfaces of the frame buffer engine.
// Depends on pmfb_pkg for field widths.
`default_nettype none

interface pmfb_in_if import pmfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [X_W-1:0]    x_pos;
  logic [Y_W-1:0]    y_pos;
  logic [BW_W-1:0]   blit_width;
  logic [BH_W-1:0]   blit_height;
  logic [DATA_W-1:0] data_byte;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, command, x_pos, y_pos, blit_width, blit_height,
                  data_byte, read_index, input ready);
  modport sink   (input valid, command, x_pos, y_pos, blit_width, blit_height,
                  data_byte, read_index, output ready);
endinterface

interface pmfb_out_if import pmfb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_byte;
  logic [STATUS_W-1:0] status;
  logic                blit_done;

  modport source (output valid, read_byte, status, blit_done, input ready);
  modport sink   (input valid, read_byte, status, blit_done, output ready);
endinterface

`default_nettype wire

@@ src/pmfb_front.sv @@
// Front end: accepts requests, checks bounds, tracks blit progress and
// turns each request into one store operation. Depends on pmfb_pkg, pmfb_if.
`default_nettype none

module pmfb_front import pmfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      init_busy_i,
  input  logic      full_i,
  output logic      push_o,
  output op_t       op_o,
  pmfb_in_if.sink   in_i
);

  logic              active_q, active_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [PG_W-1:0]   pages_q, pages_d;
  logic [COL_W-1:0]  cols_q, cols_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [COL_W-1:0]  ccnt_q, ccnt_d;

  logic [CMP_W-1:0]  x_w, y_w, w_w, h_w, r_w, blit_idx;
  logic [ADDR_W-1:0] xy_addr;
  logic [PG_W-1:0]   pc_inc;
  logic [COL_W-1:0]  cc_inc;

  assign in_i.ready = !full_i && !init_busy_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    x_w      = CMP_W'(in_i.x_pos);
    y_w      = CMP_W'(in_i.y_pos);
    w_w      = CMP_W'(in_i.blit_width);
    h_w      = CMP_W'(in_i.blit_height);
    r_w      = CMP_W'(in_i.read_index);
    xy_addr  = ADDR_W'(CMP_W'(in_i.y_pos >> 3) * CMP_W'(FRAME_COLUMNS) + x_w);
    blit_idx = CMP_W'(base_q) + CMP_W'(pcnt_q) * CMP_W'(FRAME_COLUMNS) + CMP_W'(ccnt_q);
    pc_inc   = PG_W'(pcnt_q) + PG_W'(1);
    cc_inc   = ccnt_q + COL_W'(1);

    op_o     = '{kind: OP_NOP, addr: '0, data: '0, status: ST_OK, done: 1'b0};
    active_d = active_q;
    base_d   = base_q;
    pages_d  = pages_q;
    cols_d   = cols_q;
    pcnt_d   = pcnt_q;
    ccnt_d   = ccnt_q;

    unique case (in_i.command)
      CMD_CLEAR: op_o.kind = OP_CLEAR;
      CMD_SET_PIXEL: begin
        if (x_w < CMP_W'(FRAME_COLUMNS) && y_w < CMP_W'(FRAME_ROWS)) begin
          op_o.kind = OP_SETBIT;
          op_o.addr = xy_addr;
          op_o.data = DATA_W'(1) << in_i.y_pos[2:0];
        end else begin
          op_o.status = ST_REJECT;
        end
      end
      CMD_START_BLIT: begin
        active_d = 1'b0;
        base_d   = '0;
        pages_d  = '0;
        cols_d   = '0;
        pcnt_d   = '0;
        ccnt_d   = '0;
        if (in_i.y_pos[2:0] != 3'd0 || x_w + w_w > CMP_W'(FRAME_COLUMNS)
            || y_w + h_w > CMP_W'(FRAME_ROWS)) begin
          op_o.status = ST_REJECT;
        end else begin
          base_d   = xy_addr;
          pages_d  = PG_W'(in_i.blit_height >> 3);
          cols_d   = COL_W'(in_i.blit_width);
          active_d = (pages_d != '0) && (cols_d != '0);
        end
      end
      CMD_BLIT_BYTE: begin
        if (!active_q) begin
          op_o.status = ST_IGNORED;
        end else begin
          if (blit_idx < CMP_W'(STORE_BYTES)) begin
            op_o.kind = OP_WRITE;
            op_o.addr = ADDR_W'(blit_idx);
            op_o.data = in_i.data_byte;
          end
          if (pc_inc >= pages_q) begin
            pcnt_d = '0;
            ccnt_d = cc_inc;
            if (cc_inc >= cols_q) begin
              active_d  = 1'b0;
              base_d    = '0;
              pages_d   = '0;
              cols_d    = '0;
              ccnt_d    = '0;
              op_o.done = 1'b1;
            end
          end else begin
            pcnt_d = PCNT_W'(pc_inc);
          end
        end
      end
      CMD_READ_BYTE: begin
        if (r_w < CMP_W'(STORE_BYTES)) begin
          op_o.kind = OP_READ;
          op_o.addr = ADDR_W'(r_w);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      base_q   <= '0;
      pages_q  <= '0;
      cols_q   <= '0;
      pcnt_q   <= '0;
      ccnt_q   <= '0;
    end else if (push_o) begin
      active_q <= active_d;
      base_q   <= base_d;
      pages_q  <= pages_d;
      cols_q   <= cols_d;
      pcnt_q   <= pcnt_d;
      ccnt_q   <= ccnt_d;
    end
  end

  a_active_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pages_q != '0) && (cols_q != '0))
    else $error("active blit with empty extent");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (PG_W'(pcnt_q) < pages_q) && (ccnt_q < cols_q))
    else $error("blit counters out of range");

  a_done_ends_blit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && op_o.done) |=> !active_q)
    else $error("blit still active after last byte");

endmodule

`default_nettype wire

@@ src/pmfb_queue.sv @@
// Small FIFO of store operations between front and back end.
// Depends on pmfb_pkg.
`default_nettype none

module pmfb_queue import pmfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  head_o
);

  op_t               entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ src/pmfb_back.sv @@
// Back end: owns the frame store, runs the reset and clear sweeps, does
// read-modify-write for pixels, and holds the result register.
// Depends on pmfb_pkg, pmfb_if.
`default_nettype none

module pmfb_back import pmfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       init_busy_o,
  pmfb_out_if.source out_o
);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_FETCH, S_CLEAR} state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] sweep_q;
  op_t               op_q;
  logic [DATA_W-1:0] mem [STORE_BYTES];
  logic [DATA_W-1:0] rdata_q;

  logic              out_valid_q, out_done_q;
  logic [DATA_W-1:0] out_byte_q;
  status_e           out_status_q;

  logic              slot_free, last, pop;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              emit, emit_done;
  logic [DATA_W-1:0] emit_byte;
  status_e           emit_status;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign last        = sweep_q == ADDR_W'(STORE_BYTES - 1);
  assign pop_o       = pop;
  assign init_busy_o = state_q == S_INIT;

  assign out_o.valid     = out_valid_q;
  assign out_o.read_byte = out_byte_q;
  assign out_o.status    = out_status_q;
  assign out_o.blit_done = out_done_q;

  always_comb begin
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = sweep_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = head_i.addr;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_status = ST_OK;
    emit_done   = 1'b0;
    unique case (state_q)
      S_INIT: mem_we = 1'b1;
      S_IDLE: begin
        if (!empty_i) begin
          unique case (head_i.kind)
            OP_NOP: begin
              if (slot_free) begin
                pop         = 1'b1;
                emit        = 1'b1;
                emit_status = head_i.status;
                emit_done   = head_i.done;
              end
            end
            OP_WRITE: begin
              if (slot_free) begin
                pop         = 1'b1;
                mem_we      = 1'b1;
                mem_waddr   = head_i.addr;
                mem_wdata   = head_i.data;
                emit        = 1'b1;
                emit_status = head_i.status;
                emit_done   = head_i.done;
              end
            end
            OP_SETBIT, OP_READ: begin
              pop    = 1'b1;
              mem_re = 1'b1;
            end
            OP_CLEAR: pop = 1'b1;
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = op_q.status;
          if (op_q.kind == OP_SETBIT) begin
            mem_we    = 1'b1;
            mem_waddr = op_q.addr;
            mem_wdata = rdata_q | op_q.data;
          end else begin
            emit_byte = rdata_q;
          end
        end
      end
      S_CLEAR: begin
        mem_we = !last || slot_free;
        if (last && slot_free) begin
          emit        = 1'b1;
          emit_status = op_q.status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q  <= 1'b1;
        out_byte_q   <= emit_byte;
        out_status_q <= emit_status;
        out_done_q   <= emit_done;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          if (last) begin
            sweep_q <= '0;
            state_q <= S_IDLE;
          end else begin
            sweep_q <= sweep_q + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (pop) begin
            op_q <= head_i;
            if (head_i.kind == OP_SETBIT || head_i.kind == OP_READ) begin
              state_q <= S_FETCH;
            end else if (head_i.kind == OP_CLEAR) begin
              sweep_q <= '0;
              state_q <= S_CLEAR;
            end
          end
        end
        S_FETCH: if (slot_free) state_q <= S_IDLE;
        S_CLEAR: begin
          if (mem_we) begin
            if (last) begin
              sweep_q <= '0;
              state_q <= S_IDLE;
            end else begin
              sweep_q <= sweep_q + ADDR_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !out_valid_q)
    else $error("result during reset sweep");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (state_q == S_IDLE) && !empty_i)
    else $error("queue pop outside idle");

  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> CMP_W'(mem_waddr) < CMP_W'(STORE_BYTES))
    else $error("store write beyond frame");

  a_emit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result register overwritten");

endmodule

`default_nettype wire

@@ src/paged_mono_framebuffer_engine.sv @@
// Top level of the paged monochrome frame buffer engine.
// Depends on pmfb_pkg, pmfb_if, pmfb_front, pmfb_queue, pmfb_back.
//
//  channel  dir  handshake          payload
//  in_i     in   valid/ready        command x_pos y_pos blit_width blit_height
//                                   data_byte read_index
//  out_o    out  valid/ready        read_byte status blit_done
//
// One result per request. Blit bytes, rejects and no-ops are written or answered
// straight from the queue head; set pixel and read first register a store read,
// then set pixel writes the merged byte back and read returns the byte. Clear is
// popped, then sweeps zero over all 1024 bytes of the store. After reset the same sweep runs with in_i.ready low.
// A 4-entry queue separates front and back; the store stage stalls while the
// result register holds a result that out_o has not taken.
`default_nettype none

module paged_mono_framebuffer_engine import pmfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmfb_in_if.sink    in_i,
  pmfb_out_if.source out_o
);

  logic init_busy, full, push, pop, empty;
  op_t  push_op, head_op;

  pmfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_busy_i (init_busy),
    .full_i      (full),
    .push_o      (push),
    .op_o        (push_op),
    .in_i        (in_i)
  );

  pmfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_op)
  );

  pmfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_op),
    .empty_i     (empty),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
